// ----- rtl/apv_pkg.sv -----
// ----------------------------------------------------------------------------
// apv_pkg
// Shared types and constants for the attribute predicate validator.
// ----------------------------------------------------------------------------
package apv_pkg;

  // Longest string, in bytes. Offsets saturate one below this value and
  // never go above what the 12-bit offset fields can hold.
  localparam int MAX_BYTES = 4096;
  localparam int POS_W     = 12;
  localparam int POS_MAX   = ((MAX_BYTES - 1) > ((1 << POS_W) - 1)) ?
                             ((1 << POS_W) - 1) : (MAX_BYTES - 1);

  // Queue between the classifier and the scanner
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NO_AT     = 3'd1,
    ERR_NO_NAME   = 3'd2,
    ERR_NO_LOCAL  = 3'd3,
    ERR_NO_EQUALS = 3'd4,
    ERR_NO_QUOTE  = 3'd5,
    ERR_UNCLOSED  = 3'd6,
    ERR_BAD_VALUE = 3'd7
  } err_code_e;

  typedef struct packed {
    logic [20:0] codepoint;
    logic        has_char;
    logic [2:0]  unit_bytes;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [2:0]        error_code;
    logic              has_prefix;
    logic [POS_W-1:0]  prefix_start;
    logic [POS_W-1:0]  prefix_length;
    logic [POS_W-1:0]  name_start;
    logic [POS_W-1:0]  name_length;
    logic [POS_W-1:0]  value_start;
    logic [POS_W-1:0]  value_length;
  } result_t;

  // Character class flags worked out by the front end
  typedef struct packed {
    logic at_sign;
    logic nc_start;
    logic nc_char;
    logic colon;
    logic equals;
    logic dquote;
    logic squote;
    logic amp;
    logic less;
    logic hash;
    logic x_lower;
    logic digit;
    logic hex;
    logic semi;
  } char_class_t;

  // One classified item as queued for the scanner
  typedef struct packed {
    char_class_t cls;
    logic        has_char;
    logic [2:0]  unit_bytes;
    logic        last;
  } token_t;

endpackage

// ----- rtl/apv_front.sv -----
// ----------------------------------------------------------------------------
// apv_front
// Input side: classifies each codepoint and writes it into the token queue.
// ----------------------------------------------------------------------------
module apv_front
  import apv_pkg::*;
(
  input  logic     push,
  input  in_item_t item_i,
  input  logic     q_full_i,
  output logic     q_we_o,
  output token_t   q_wdata_o
);

  function automatic logic in_rng(input logic [20:0] c, input logic [20:0] lo,
                                  input logic [20:0] hi);
    in_rng = (c >= lo) && (c <= hi);
  endfunction

  function automatic logic nc_start_f(input logic [20:0] c);
    nc_start_f = in_rng(c, 21'h41, 21'h5a) || in_rng(c, 21'h61, 21'h7a) ||
                 (c == 21'h5f) ||
                 in_rng(c, 21'h00c0, 21'h00d6) || in_rng(c, 21'h00d8, 21'h00f6) ||
                 in_rng(c, 21'h00f8, 21'h02ff) || in_rng(c, 21'h0370, 21'h037d) ||
                 in_rng(c, 21'h037f, 21'h1fff) || in_rng(c, 21'h200c, 21'h200d) ||
                 in_rng(c, 21'h2070, 21'h218f) || in_rng(c, 21'h2c00, 21'h2fef) ||
                 in_rng(c, 21'h3001, 21'hd7ff) || in_rng(c, 21'hf900, 21'hfdcf) ||
                 in_rng(c, 21'hfdf0, 21'hfffd) || in_rng(c, 21'h10000, 21'heffff);
  endfunction

  logic [20:0] cp;
  logic        is_digit;
  logic        is_start;

  assign cp       = item_i.codepoint;
  assign is_digit = in_rng(cp, 21'h30, 21'h39);
  assign is_start = nc_start_f(cp);

  always_comb begin
    q_wdata_o.cls.at_sign  = (cp == 21'h40);
    q_wdata_o.cls.nc_start = is_start;
    q_wdata_o.cls.nc_char  = is_start || (cp == 21'h2d) || (cp == 21'h2e) ||
                             (cp == 21'hb7) || is_digit ||
                             in_rng(cp, 21'h0300, 21'h036f) ||
                             in_rng(cp, 21'h203f, 21'h2040);
    q_wdata_o.cls.colon    = (cp == 21'h3a);
    q_wdata_o.cls.equals   = (cp == 21'h3d);
    q_wdata_o.cls.dquote   = (cp == 21'h22);
    q_wdata_o.cls.squote   = (cp == 21'h27);
    q_wdata_o.cls.amp      = (cp == 21'h26);
    q_wdata_o.cls.less     = (cp == 21'h3c);
    q_wdata_o.cls.hash     = (cp == 21'h23);
    q_wdata_o.cls.x_lower  = (cp == 21'h78);
    q_wdata_o.cls.digit    = is_digit;
    q_wdata_o.cls.hex      = is_digit || in_rng(cp, 21'h61, 21'h66) ||
                             in_rng(cp, 21'h41, 21'h46);
    q_wdata_o.cls.semi     = (cp == 21'h3b);
    q_wdata_o.has_char     = item_i.has_char;
    q_wdata_o.unit_bytes   = item_i.unit_bytes;
    q_wdata_o.last         = item_i.last;
  end

  assign q_we_o = push && !q_full_i;

endmodule

// ----- rtl/apv_queue.sv -----
// ----------------------------------------------------------------------------
// apv_queue
// Small token FIFO decoupling the classifier from the scanner.
// ----------------------------------------------------------------------------
module apv_queue
  import apv_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   we_i,
  input  token_t wdata_i,
  output logic   full_o,
  output logic   valid_o,
  output token_t rdata_o,
  input  logic   take_i
);

  token_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_rd;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_rd   = take_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (we_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({we_i, do_rd})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/apv_back.sv -----
// ----------------------------------------------------------------------------
// apv_back
// Scanner: walks the attribute test grammar one token per cycle (a last token
// waits while a verdict is unpopped) and holds the verdict in an output register until it is popped.
// ----------------------------------------------------------------------------
module apv_back
  import apv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  token_t  q_rdata_i,
  output logic    q_take_o,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  typedef enum logic [7:0] {
    PH_AT          = 8'b0000_0001,
    PH_NAME_START  = 8'b0000_0010,
    PH_NAME        = 8'b0000_0100,
    PH_LOCAL_START = 8'b0000_1000,
    PH_LOCAL       = 8'b0001_0000,
    PH_QUOTE       = 8'b0010_0000,
    PH_VALUE       = 8'b0100_0000,
    PH_DONE        = 8'b1000_0000
  } phase_e;

  typedef enum logic [8:0] {
    VP_START = 9'b0_0000_0001,
    VP_TEXT  = 9'b0_0000_0010,
    VP_AMP   = 9'b0_0000_0100,
    VP_HASH  = 9'b0_0000_1000,
    VP_HEX   = 9'b0_0001_0000,
    VP_DEC   = 9'b0_0010_0000,
    VP_NAME  = 9'b0_0100_0000,
    VP_SEMI  = 9'b0_1000_0000,
    VP_BAD   = 9'b1_0000_0000
  } vphase_e;

  localparam logic [POS_W-1:0] POS_MAX_C = POS_W'(POS_MAX);

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [2:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {{(POS_W - 2){1'b0}}, b};
    sat_add = (s > {1'b0, POS_MAX_C}) ? POS_MAX_C : s[POS_W-1:0];
  endfunction

  phase_e           phase_q, phase_d;
  vphase_e          vphase_q, vphase_d;
  logic             apos_q, apos_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] fstart_q, fstart_d;
  logic [POS_W-1:0] flen_q, flen_d;
  logic [POS_W-1:0] lstart_q, lstart_d;
  logic [POS_W-1:0] llen_q, llen_d;
  logic [POS_W-1:0] vbegin_q, vbegin_d;
  logic             pfx_q, pfx_d;
  err_code_e        fault_q, fault_d;
  err_code_e        final_err;

  logic             out_valid_q;
  result_t          res_q, res_d;

  char_class_t      cls;
  logic             active;
  logic             close_hit;

  assign cls       = q_rdata_i.cls;
  assign q_take_o  = q_valid_i && (!q_rdata_i.last || !out_valid_q || pop);
  assign active    = q_rdata_i.has_char && (fault_q == ERR_OK) && (phase_q != PH_DONE);
  assign close_hit = apos_q ? cls.squote : cls.dquote;

  always_comb begin
    phase_d  = phase_q;
    vphase_d = vphase_q;
    apos_d   = apos_q;
    pos_d    = pos_q;
    fstart_d = fstart_q;
    flen_d   = flen_q;
    lstart_d = lstart_q;
    llen_d   = llen_q;
    vbegin_d = vbegin_q;
    pfx_d    = pfx_q;
    fault_d  = fault_q;

    if (active) begin
      case (phase_q)
        PH_AT: begin
          if (cls.at_sign) phase_d = PH_NAME_START;
          else fault_d = ERR_NO_AT;
        end
        PH_NAME_START: begin
          if (cls.nc_start) begin
            fstart_d = pos_q;
            phase_d  = PH_NAME;
          end else begin
            fault_d = ERR_NO_NAME;
          end
        end
        PH_NAME: begin
          if (!cls.nc_char) begin
            if (cls.colon) begin
              pfx_d   = 1'b1;
              flen_d  = pos_q - fstart_q;
              phase_d = PH_LOCAL_START;
            end else if (cls.equals) begin
              lstart_d = fstart_q;
              llen_d   = pos_q - fstart_q;
              phase_d  = PH_QUOTE;
            end else begin
              fault_d = ERR_NO_EQUALS;
            end
          end
        end
        PH_LOCAL_START: begin
          if (cls.nc_start) begin
            lstart_d = pos_q;
            phase_d  = PH_LOCAL;
          end else begin
            fault_d = ERR_NO_LOCAL;
          end
        end
        PH_LOCAL: begin
          if (!cls.nc_char) begin
            if (cls.equals) begin
              llen_d  = pos_q - lstart_q;
              phase_d = PH_QUOTE;
            end else begin
              fault_d = ERR_NO_EQUALS;
            end
          end
        end
        PH_QUOTE: begin
          if (cls.dquote || cls.squote) begin
            apos_d   = cls.squote;
            vbegin_d = sat_add(pos_q, q_rdata_i.unit_bytes);
            vphase_d = VP_START;
            phase_d  = PH_VALUE;
          end else begin
            fault_d = ERR_NO_QUOTE;
          end
        end
        PH_VALUE: begin
          if (close_hit) begin
            phase_d = PH_DONE;
            if (!(vphase_q == VP_START || vphase_q == VP_TEXT || vphase_q == VP_SEMI))
              fault_d = ERR_BAD_VALUE;
          end else begin
            case (vphase_q)
              VP_START: begin
                if (cls.amp) vphase_d = VP_AMP;
                else if (cls.less) vphase_d = VP_BAD;
                else vphase_d = VP_TEXT;
              end
              VP_TEXT: begin
                if (cls.less || cls.amp) vphase_d = VP_BAD;
              end
              VP_AMP: begin
                if (cls.hash) vphase_d = VP_HASH;
                else if (cls.nc_start || cls.colon) vphase_d = VP_NAME;
                else vphase_d = VP_BAD;
              end
              VP_HASH: begin
                if (cls.x_lower) vphase_d = VP_HEX;
                else if (cls.digit) vphase_d = VP_DEC;
                else if (cls.semi) vphase_d = VP_SEMI;
                else vphase_d = VP_BAD;
              end
              VP_HEX: begin
                if (cls.semi) vphase_d = VP_SEMI;
                else if (!cls.hex) vphase_d = VP_BAD;
              end
              VP_DEC: begin
                if (cls.semi) vphase_d = VP_SEMI;
                else if (!cls.digit) vphase_d = VP_BAD;
              end
              VP_NAME: begin
                if (cls.semi) vphase_d = VP_SEMI;
                else if (!(cls.nc_char || cls.colon)) vphase_d = VP_BAD;
              end
              default: vphase_d = VP_BAD;
            endcase
          end
        end
        default: ;
      endcase
      if (fault_d == ERR_OK && phase_d != PH_DONE) begin
        pos_d = sat_add(pos_q, q_rdata_i.unit_bytes);
      end
    end
  end

  // Verdict for a token marked last
  always_comb begin
    final_err = fault_d;
    if (fault_d == ERR_OK && phase_d != PH_DONE) begin
      case (phase_d)
        PH_AT:          final_err = ERR_NO_AT;
        PH_NAME_START:  final_err = ERR_NO_NAME;
        PH_LOCAL_START: final_err = ERR_NO_LOCAL;
        PH_QUOTE:       final_err = ERR_NO_QUOTE;
        PH_VALUE:       final_err = ERR_UNCLOSED;
        default:        final_err = ERR_NO_EQUALS;
      endcase
    end
    res_d            = '0;
    res_d.error_code = final_err;
    if (final_err == ERR_OK) begin
      res_d.accepted     = 1'b1;
      res_d.has_prefix   = pfx_d;
      if (pfx_d) begin
        res_d.prefix_start  = fstart_d;
        res_d.prefix_length = flen_d;
      end
      res_d.name_start   = lstart_d;
      res_d.name_length  = llen_d;
      res_d.value_start  = vbegin_d;
      res_d.value_length = pos_d - vbegin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_AT;
      vphase_q <= VP_START;
      apos_q   <= 1'b0;
      pos_q    <= '0;
      fstart_q <= '0;
      flen_q   <= '0;
      lstart_q <= '0;
      llen_q   <= '0;
      vbegin_q <= '0;
      pfx_q    <= 1'b0;
      fault_q  <= ERR_OK;
    end else if (q_take_o) begin
      if (q_rdata_i.last) begin
        phase_q  <= PH_AT;
        vphase_q <= VP_START;
        apos_q   <= 1'b0;
        pos_q    <= '0;
        fstart_q <= '0;
        flen_q   <= '0;
        lstart_q <= '0;
        llen_q   <= '0;
        vbegin_q <= '0;
        pfx_q    <= 1'b0;
        fault_q  <= ERR_OK;
      end else begin
        phase_q  <= phase_d;
        vphase_q <= vphase_d;
        apos_q   <= apos_d;
        pos_q    <= pos_d;
        fstart_q <= fstart_d;
        flen_q   <= flen_d;
        lstart_q <= lstart_d;
        llen_q   <= llen_d;
        vbegin_q <= vbegin_d;
        pfx_q    <= pfx_d;
        fault_q  <= fault_d;
      end
    end
  end

  // Output register: filled by a last token, drained by pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_take_o && q_rdata_i.last) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_take_o && q_rdata_i.last) begin
      res_q <= res_d;
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = res_q;

endmodule

// ----- rtl/attribute_predicate_validator_unit.sv -----
// ----------------------------------------------------------------------------
// attribute_predicate_validator_unit
// Streaming checker for the attribute test of a node selector.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (push/full): one decoded codepoint per transaction, with
//    its UTF-8 byte count, a has_char flag (0 = empty end marker) and last.
//    A transaction completes on a clock edge with push high and full low.
//  - Result channel (empty/pop): one verdict per string, produced by the
//    transaction marked last. The oldest verdict sits on result_o while
//    empty is low and is taken on an edge with pop high.
//  - Throughput: one codepoint per cycle while no last token is held. The
//    front end classifies the character and writes it into a four-entry
//    token queue; the scanner takes one token per cycle from that queue.
//  - Path: a last transaction is written into the token queue; the scanner
//    then takes it and loads its verdict into the output register.
//  - Stalls: if a verdict is still waiting, the scanner keeps consuming
//    ordinary tokens and only holds a last token; the queue absorbs the
//    rest, and full rises once it holds four tokens.
//  - Reset: asynchronous, active low; the queue and output register are
//    emptied and the scanner returns to expecting '@'.
// ----------------------------------------------------------------------------
module attribute_predicate_validator_unit
  import apv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t item_i,
  output logic     empty,
  input  logic     pop,
  output result_t  result_o
);

  logic   q_we;
  token_t q_wdata;
  logic   q_valid;
  token_t q_rdata;
  logic   q_take;

  // Classify and enqueue
  apv_front u_front (
    .push      (push),
    .item_i    (item_i),
    .q_full_i  (full),
    .q_we_o    (q_we),
    .q_wdata_o (q_wdata)
  );

  apv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (q_we),
    .wdata_i (q_wdata),
    .full_o  (full),
    .valid_o (q_valid),
    .rdata_o (q_rdata),
    .take_i  (q_take)
  );

  // Grammar scan and verdict register
  apv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_rdata_i (q_rdata),
    .q_take_o  (q_take),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

// ----- rtl/apv_checker.sv -----
// ----------------------------------------------------------------------------
// apv_checker
// Port-level checks for the attribute predicate validator.
// ----------------------------------------------------------------------------
module apv_checker
  import apv_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input result_t  result_o
);

  // Reset leaves no verdict behind
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("verdict visible after reset");

  // accepted and error code agree
  a_ok_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.accepted == (result_o.error_code == ERR_OK)))
    else $error("accepted flag disagrees with error code");

  // Rejected strings carry no offsets
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.accepted) |->
      (!result_o.has_prefix && result_o.prefix_start == '0 &&
       result_o.prefix_length == '0 && result_o.name_start == '0 &&
       result_o.name_length == '0 && result_o.value_start == '0 &&
       result_o.value_length == '0))
    else $error("rejected verdict carries offsets");

  // No prefix means zero prefix fields
  a_no_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.has_prefix) |->
      (result_o.prefix_start == '0 && result_o.prefix_length == '0))
    else $error("prefix fields set without prefix");

  // A waiting verdict holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting verdict changed");

endmodule

bind attribute_predicate_validator_unit apv_checker u_apv_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
